// File: design/emsm_pkg.sv
// Shared types and constants of the smoothed class-probability median filter.
package emsm_pkg;

  // Frame layout fixed by the field widths of the channels.
  localparam int CLASS_COUNT = 7;
  localparam int CLASS_IDX_W = 3;
  localparam int SAMPLE_BITS = 16;

  // Smoothing weight in Q1.16, where ALPHA_ONE stands for 1.0.
  localparam int ALPHA_W = 17;
  localparam int ALPHA_FRAC = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;

  // Window length register.
  localparam int WIN_W = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd60;

  // Configuration write channel.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 8'd1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t prob_class0;
    sample_t prob_class1;
    sample_t prob_class2;
    sample_t prob_class3;
    sample_t prob_class4;
    sample_t prob_class5;
    sample_t prob_class6;
  } in_payload_t;

  typedef struct packed {
    sample_t median_class0;
    sample_t median_class1;
    sample_t median_class2;
    sample_t median_class3;
    sample_t median_class4;
    sample_t median_class5;
    sample_t median_class6;
  } out_payload_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_payload_t;

endpackage

// File: design/emsm_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
interface emsm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/emsm_ema.sv
// Exponential moving average over the class lanes, one class per cycle on one multiplier.
module emsm_ema (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  emsm_pkg::sample_t                    sample_i [emsm_pkg::CLASS_COUNT],
  input  logic [emsm_pkg::ALPHA_W-1:0]         alpha_i,
  output emsm_pkg::sample_t                    smooth_o [emsm_pkg::CLASS_COUNT],
  output logic                                 done_o
);

  localparam int IDX_W = emsm_pkg::CLASS_IDX_W;
  localparam int SB = emsm_pkg::SAMPLE_BITS;
  localparam int PROD_W = emsm_pkg::ALPHA_W + SB + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(emsm_pkg::CLASS_COUNT - 1);

  emsm_pkg::sample_t x_q [emsm_pkg::CLASS_COUNT];
  emsm_pkg::sample_t sm_q [emsm_pkg::CLASS_COUNT];
  emsm_pkg::sample_t x2_q;
  emsm_pkg::sample_t avg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] p_idx_q;
  logic             issue_q;
  logic             p_vld_q;
  logic             started_q;
  logic             done_q;

  logic signed [emsm_pkg::ALPHA_W:0] alpha_s;
  logic signed [SB:0]                diff_s;
  logic signed [PROD_W-1:0]          base_s;
  logic signed [PROD_W-1:0]          acc_s;
  emsm_pkg::sample_t                 ema_val;

  // The step is rewritten as avg + alpha*(x - avg), so one signed multiply suffices.
  assign alpha_s = $signed({1'b0, alpha_i});
  assign diff_s  = $signed({1'b0, x_q[idx_q]}) - $signed({1'b0, sm_q[idx_q]});
  assign base_s  = $signed({{(PROD_W-SB-emsm_pkg::ALPHA_FRAC){1'b0}}, avg_q,
                            {emsm_pkg::ALPHA_FRAC{1'b0}}});
  assign acc_s   = base_s + prod_q;
  assign ema_val = acc_s[emsm_pkg::ALPHA_FRAC +: SB];

  // Sequencing of the two stages and the smoothed state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= 1'b0;
      idx_q     <= '0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      started_q <= 1'b0;
      done_q    <= 1'b0;
      for (int c = 0; c < emsm_pkg::CLASS_COUNT; c++) begin
        sm_q[c] <= '0;
      end
    end else begin
      if (start_i) begin
        issue_q <= 1'b1;
        idx_q   <= '0;
      end else if (issue_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          issue_q <= 1'b0;
        end
      end
      p_vld_q <= issue_q;
      p_idx_q <= idx_q;
      done_q  <= p_vld_q && (p_idx_q == LAST_IDX);
      if (p_vld_q) begin
        // The first frame after reset loads the average directly.
        sm_q[p_idx_q] <= started_q ? ema_val : x2_q;
        if (p_idx_q == LAST_IDX) begin
          started_q <= 1'b1;
        end
      end
    end
  end

  // Frame capture and the multiply stage.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= sample_i;
    end
    if (issue_q) begin
      x2_q   <= x_q[idx_q];
      avg_q  <= sm_q[idx_q];
      prod_q <= alpha_s * diff_s;
    end
  end

  assign smooth_o = sm_q;
  assign done_o   = done_q;

endmodule

// File: design/emsm_lane.sv
// One class lane: a sorted list of held frames in a two-bank memory, merged and ranked per frame.
module emsm_lane #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  emsm_pkg::sample_t                   value_i,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]   held_i,
  input  logic                                full_i,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]     slot_i,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]   count_i,
  output logic                                busy_o,
  output emsm_pkg::sample_t                   median_o
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SB = emsm_pkg::SAMPLE_BITS;
  localparam int ENT_W = SB + SLOT_W;
  localparam int AGE_W = CNT_W + 1;
  localparam int MEM_DEPTH = 2 ** (SLOT_W + 1);

  // Each entry holds a smoothed value and the ring slot of the frame it came from.
  logic [ENT_W-1:0] mem [MEM_DEPTH];
  logic [ENT_W-1:0] rdata_q;
  logic [ENT_W-1:0] hold_q, hold_d;
  logic             hold_vld_q, hold_vld_d;
  logic             ins_q, ins_d;
  logic             busy_q;
  logic             bank_q;
  logic             rd_vld_q;
  logic [CNT_W-1:0] rd_idx_q;
  logic [CNT_W-1:0] wr_idx_q;
  logic [CNT_W-1:0] cnt_q;
  emsm_pkg::sample_t v_q;
  emsm_pkg::sample_t med_q;
  logic [CNT_W-1:0]  m_q;
  logic [CNT_W-1:0]  n_q;
  logic              full_q;
  logic [SLOT_W-1:0] ws_q;

  logic              rd_en;
  logic              fin;
  emsm_pkg::sample_t d_val;
  logic [SLOT_W-1:0] d_slot;
  logic              evict;
  logic [ENT_W-1:0]  new_ent;
  logic              emit_vld;
  logic [ENT_W-1:0]  emit_ent;
  logic [AGE_W-1:0]  ws_ext, s_ext, age;
  logic              in_win;

  assign rd_en   = busy_q && (rd_idx_q < m_q);
  assign fin     = busy_q && !(rd_idx_q < m_q) && !rd_vld_q;
  assign d_val   = rdata_q[ENT_W-1:SLOT_W];
  assign d_slot  = rdata_q[SLOT_W-1:0];
  assign evict   = full_q && (d_slot == ws_q);
  assign new_ent = {v_q, ws_q};

  // Merge step: drop the evicted frame, insert the new one ahead of the first larger value.
  // A single holding entry absorbs the one-place shift that the insertion causes.
  always_comb begin
    emit_vld   = 1'b0;
    emit_ent   = new_ent;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    ins_d      = ins_q;
    if (busy_q && rd_vld_q) begin
      if (hold_vld_q) begin
        emit_vld   = 1'b1;
        emit_ent   = hold_q;
        hold_vld_d = !evict;
        hold_d     = rdata_q;
      end else if (!ins_q && !evict && (v_q < d_val)) begin
        emit_vld   = 1'b1;
        emit_ent   = new_ent;
        ins_d      = 1'b1;
        hold_vld_d = 1'b1;
        hold_d     = rdata_q;
      end else if (!evict) begin
        emit_vld = 1'b1;
        emit_ent = rdata_q;
      end
    end else if (fin) begin
      if (hold_vld_q) begin
        emit_vld   = 1'b1;
        emit_ent   = hold_q;
        hold_vld_d = 1'b0;
      end else if (!ins_q) begin
        emit_vld = 1'b1;
        emit_ent = new_ent;
        ins_d    = 1'b1;
      end
    end
  end

  // Age of an emitted entry, counted back from the newest frame.
  assign ws_ext = AGE_W'(ws_q);
  assign s_ext  = AGE_W'(emit_ent[SLOT_W-1:0]);
  assign age    = (ws_ext >= s_ext) ? (ws_ext - s_ext)
                                    : (ws_ext + AGE_W'(WINDOW_DEPTH) - s_ext);
  assign in_win = age < AGE_W'(n_q);

  // Lane control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      bank_q     <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      cnt_q      <= '0;
      ins_q      <= 1'b0;
      hold_vld_q <= 1'b0;
    end else if (start_i) begin
      busy_q     <= 1'b1;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      cnt_q      <= '0;
      ins_q      <= 1'b0;
      hold_vld_q <= 1'b0;
    end else if (busy_q) begin
      rd_vld_q   <= rd_en;
      ins_q      <= ins_d;
      hold_vld_q <= hold_vld_d;
      if (rd_en) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (emit_vld) begin
        wr_idx_q <= wr_idx_q + 1'b1;
      end
      if (emit_vld && in_win) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // The freshly written bank becomes the one read by the next frame.
      if (fin) begin
        busy_q <= 1'b0;
        bank_q <= ~bank_q;
      end
    end
  end

  // Command capture, median capture and the memory. Banks never overlap within a pass.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= value_i;
      m_q    <= held_i;
      full_q <= full_i;
      ws_q   <= slot_i;
      n_q    <= count_i;
    end
    hold_q <= hold_d;
    if (emit_vld && in_win && (cnt_q == (n_q >> 1))) begin
      med_q <= emit_ent[ENT_W-1:SLOT_W];
    end
    if (rd_en) begin
      rdata_q <= mem[{bank_q, rd_idx_q[SLOT_W-1:0]}];
    end
    if (emit_vld) begin
      mem[{~bank_q, wr_idx_q[SLOT_W-1:0]}] <= emit_ent;
    end
  end

  assign busy_o   = busy_q;
  assign median_o = med_q;

endmodule

// File: design/ema_then_sliding_median.sv
// Sequence: smoothing of the frame, then the merge pass of each lane, which reads one memory
// entry per cycle over held, the frames stored before the frame (at most WINDOW_DEPTH); the
// wait for the result grows with held.
// Throughput: one frame at a time; the input reopens as the result is registered.
// Reset: registers take their reset values and the history is empty; memory is read once written.
module ema_then_sliding_median #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  emsm_chan_if.sink   in_i,
  emsm_chan_if.source out_o,
  emsm_chan_if.sink   cfg_i
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = (CNT_W > emsm_pkg::WIN_W) ? CNT_W : emsm_pkg::WIN_W;
  localparam int C = emsm_pkg::CLASS_COUNT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMA,
    ST_SORT,
    ST_DONE
  } state_e;

  state_e state_q;
  logic [emsm_pkg::ALPHA_W-1:0] alpha_q;
  logic [emsm_pkg::WIN_W-1:0]   win_q;
  logic [SLOT_W-1:0]            wptr_q;
  logic [CNT_W-1:0]             held_q;
  logic                         lane_start_q;
  logic [CNT_W-1:0]             cmd_held_q;
  logic                         cmd_full_q;
  logic [SLOT_W-1:0]            cmd_slot_q;
  logic [CNT_W-1:0]             cmd_count_q;
  logic                         out_vld_q;
  emsm_pkg::out_payload_t       out_q;

  logic                         in_acc;
  logic                         out_acc;
  logic                         out_load;
  logic [emsm_pkg::ALPHA_W-1:0] alpha_eff;
  logic [CW-1:0]                win_ext;
  logic [CNT_W-1:0]             win_eff;
  logic                         full;
  logic [CNT_W-1:0]             held_new;
  logic [CNT_W-1:0]             count_new;
  logic                         ema_done;
  logic [C-1:0]                 lane_busy;
  emsm_pkg::sample_t            samples [C];
  emsm_pkg::sample_t            smooth [C];
  emsm_pkg::sample_t            median [C];

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Register limits: alpha saturates at one, the window is clamped to 1..WINDOW_DEPTH.
  assign alpha_eff = (alpha_q > emsm_pkg::ALPHA_ONE) ? emsm_pkg::ALPHA_ONE : alpha_q;
  assign win_ext   = CW'(win_q);
  assign win_eff   = (win_q == '0) ? CNT_W'(1)
                   : (win_ext > CW'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                   : CNT_W'(win_q);
  assign full      = (held_q == CNT_W'(WINDOW_DEPTH));
  assign held_new  = full ? held_q : (held_q + 1'b1);
  assign count_new = (held_new < win_eff) ? held_new : win_eff;

  assign samples[0] = in_i.payload.prob_class0;
  assign samples[1] = in_i.payload.prob_class1;
  assign samples[2] = in_i.payload.prob_class2;
  assign samples[3] = in_i.payload.prob_class3;
  assign samples[4] = in_i.payload.prob_class4;
  assign samples[5] = in_i.payload.prob_class5;
  assign samples[6] = in_i.payload.prob_class6;

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= emsm_pkg::ALPHA_RESET;
      win_q   <= emsm_pkg::WIN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.reg_index)
        emsm_pkg::CFG_ALPHA:  alpha_q <= cfg_i.payload.wr_data[emsm_pkg::ALPHA_W-1:0];
        emsm_pkg::CFG_WINDOW: win_q   <= cfg_i.payload.wr_data[emsm_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame sequencer: smoothing, lane launch, result hand-over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wptr_q       <= '0;
      held_q       <= '0;
      lane_start_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      lane_start_q <= 1'b0;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_acc) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_EMA;
          end
        end
        ST_EMA: begin
          if (ema_done) begin
            lane_start_q <= 1'b1;
            held_q       <= held_new;
            wptr_q       <= (wptr_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : (wptr_q + 1'b1);
            state_q      <= ST_SORT;
          end
        end
        ST_SORT: begin
          if (!lane_start_q && (lane_busy == '0)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Lane command and result payload.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMA) && ema_done) begin
      cmd_held_q  <= held_q;
      cmd_full_q  <= full;
      cmd_slot_q  <= wptr_q;
      cmd_count_q <= count_new;
    end
    if (out_load) begin
      out_q.median_class0 <= median[0];
      out_q.median_class1 <= median[1];
      out_q.median_class2 <= median[2];
      out_q.median_class3 <= median[3];
      out_q.median_class4 <= median[4];
      out_q.median_class5 <= median[5];
      out_q.median_class6 <= median[6];
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  emsm_ema u_ema (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .sample_i (samples),
    .alpha_i  (alpha_eff),
    .smooth_o (smooth),
    .done_o   (ema_done)
  );

  for (genvar c = 0; c < C; c++) begin : g_lane
    emsm_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (lane_start_q),
      .value_i  (smooth[c]),
      .held_i   (cmd_held_q),
      .full_i   (cmd_full_q),
      .slot_i   (cmd_slot_q),
      .count_i  (cmd_count_q),
      .busy_o   (lane_busy[c]),
      .median_o (median[c])
    );
  end

endmodule

// File: design/emsm_checker.sv
// Port-level checks of the median filter, bound to its top level.
module emsm_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input emsm_pkg::out_payload_t out_payload_i
);

  logic [1:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Frames taken in and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // One frame in flight plus one result waiting is the most the block holds.
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more frames outstanding than the block can hold");

  // A result is only offered for a frame that was taken in.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != 2'd0))
    else $error("result offered with no frame outstanding");

  // A frame occupies the datapath, so the input closes after each transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input still open right after a transaction");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i)))
    else $error("stalled result changed or was withdrawn");

endmodule

bind ema_then_sliding_median emsm_checker u_emsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

// File: verif/tb.sv
// Self-checking testbench of the smoothed class-probability median filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import emsm_pkg::*;

  localparam int DEPTH = 64;
  localparam int FLAT_W = CLASS_COUNT * SAMPLE_BITS;
  localparam int RANDOM_FRAMES = 1750;
  localparam int QUIET_TAIL = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = DEPTH + 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_WINDOW + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  typedef logic [FLAT_W-1:0] frame_bits_t;

  typedef enum logic {STEP_FRAME, STEP_REG} step_kind_e;

  typedef struct {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
    in_payload_t           frame;
    bit                    echoes_input;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  emsm_chan_if #(.payload_t(in_payload_t))  frame_ch ();
  emsm_chan_if #(.payload_t(out_payload_t)) median_ch ();
  emsm_chan_if #(.payload_t(cfg_payload_t)) cfg_ch ();

  ema_then_sliding_median #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (frame_ch),
    .out_o (median_ch),
    .cfg_i (cfg_ch)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and smoothing history.
  logic [ALPHA_W-1:0] alpha_reg = ALPHA_RESET;
  logic [WIN_W-1:0]   window_reg = WIN_RESET;
  sample_t            lane_avg[CLASS_COUNT];
  bit                 avg_loaded = 1'b0;
  sample_t            frame_hist[DEPTH][CLASS_COUNT];
  int unsigned        hist_wr = 0;
  int unsigned        hist_count = 0;

  frame_bits_t median_queue[$];
  int unsigned errors = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b0;

  // Smooth one frame into the history and return the per-class medians.
  function automatic frame_bits_t smooth_and_rank(in_payload_t frame);
    frame_bits_t        xin;
    frame_bits_t        med;
    logic [ALPHA_W-1:0] weight;
    logic [33:0]        acc;
    sample_t            x;
    int unsigned        span;
    int unsigned        slot;
    sample_t            lane_vals[$];
    xin = frame;
    med = '0;
    weight = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    span = (window_reg == 0) ? 1 : (window_reg > DEPTH) ? DEPTH : int'(window_reg);
    for (int c = 0; c < CLASS_COUNT; c++) begin
      x = xin[SAMPLE_BITS*(CLASS_COUNT-1-c) +: SAMPLE_BITS];
      if (!avg_loaded) begin
        lane_avg[c] = x;
      end else begin
        acc = 34'(weight) * 34'(x) + 34'(ALPHA_ONE - weight) * 34'(lane_avg[c]);
        lane_avg[c] = acc[ALPHA_FRAC +: SAMPLE_BITS];
      end
    end
    avg_loaded = 1'b1;
    frame_hist[hist_wr] = lane_avg;
    hist_wr = (hist_wr + 1) % DEPTH;
    if (hist_count < DEPTH) hist_count++;
    if (hist_count < span) span = hist_count;
    // The element of rank floor(span/2) among the newest frames, per class.
    for (int c = 0; c < CLASS_COUNT; c++) begin
      lane_vals.delete();
      for (int k = 0; k < span; k++) begin
        slot = (hist_wr + 2 * DEPTH - 1 - k) % DEPTH;
        lane_vals = {lane_vals, frame_hist[slot][c]};
      end
      lane_vals.sort();
      med[SAMPLE_BITS*(CLASS_COUNT-1-c) +: SAMPLE_BITS] = lane_vals[span / 2];
    end
    return med;
  endfunction

  function automatic step_t frame_row(in_payload_t frame, bit echoes_input);
    step_t s;
    s = '{STEP_FRAME, '0, '0, frame, echoes_input};
    return s;
  endfunction

  function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '{STEP_REG, idx, data, '0, 1'b0};
    return s;
  endfunction

  // Offer one frame; on acceptance the expected medians are queued.
  task automatic send_frame(in_payload_t frame, bit echoes_input);
    frame_bits_t predicted;
    frame_ch.valid   <= 1'b1;
    frame_ch.payload <= frame;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    predicted = smooth_and_rank(frame);
    median_queue = {median_queue, (echoes_input ? frame_bits_t'(frame) : predicted)};
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int unsigned cycles);
    frame_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    frame_ch.valid <= 1'b0;
    while (median_queue.size() != 0) @(negedge clk_i);
  endtask

  // Register writes happen only once every outstanding result has come back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{reg_index: idx, wr_data: data};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == CFG_ALPHA) begin
      alpha_reg = data;
    end else if (idx == CFG_WINDOW) begin
      window_reg = data[WIN_W-1:0];
    end
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side back-pressure in bursts of random length.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      median_ch.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      median_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      median_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin : check_medians
    frame_bits_t want;
    frame_bits_t got;
    sample_t     want_lane;
    sample_t     got_lane;
    if (rst_ni && median_ch.valid && median_ch.ready) begin
      got = median_ch.payload;
      if (median_queue.size() == 0) begin
        $error("median result with no frame outstanding: %h", got);
        errors++;
      end else begin
        want = median_queue[0];
        median_queue.delete(0);
        for (int c = 0; c < CLASS_COUNT; c++) begin
          want_lane = want[SAMPLE_BITS*(CLASS_COUNT-1-c) +: SAMPLE_BITS];
          got_lane  = got[SAMPLE_BITS*(CLASS_COUNT-1-c) +: SAMPLE_BITS];
          if (want_lane !== got_lane) begin
            $error("median_class%0d: expected %0d, actual %0d", c, want_lane, got_lane);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus: directed table first, then random phases between register writes.
  initial begin
    step_t                 plan[$];
    frame_bits_t           bits;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           sent;
    int unsigned           phase_len;
    int unsigned           frame_mode;
    bit                    last_stretch;
    sample_t               lane;

    rst_ni           = 1'b0;
    frame_ch.valid   = 1'b0;
    frame_ch.payload = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.payload   = '0;
    median_ch.ready  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // The first frame loads the average, so its medians equal its samples.
    plan = {plan, frame_row('{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
                              16'h0001, 16'hFFFE, 16'h5555}, 1'b1)};
    plan = {plan, frame_row('{7{16'hFFFF}}, 1'b0)};
    plan = {plan, frame_row('{7{16'h0000}}, 1'b0)};
    plan = {plan, frame_row('{16'h0001, 16'hFFFF, 16'h1234, 16'hFEDC,
                              16'h8001, 16'h7FFE, 16'hAAAA}, 1'b0)};
    // Full weight on the new sample and a one-frame window pass frames through.
    plan = {plan, reg_row(CFG_ALPHA, ALPHA_ONE)};
    plan = {plan, reg_row(CFG_WINDOW, 17'd1)};
    plan = {plan, frame_row('{16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0,
                              16'h00FF, 16'hFF00, 16'h1234}, 1'b1)};
    // A weight above one acts as one, and a zero window as a single frame.
    plan = {plan, reg_row(CFG_ALPHA, 17'h1FFFF)};
    plan = {plan, reg_row(CFG_WINDOW, 17'd0)};
    plan = {plan, frame_row('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                              16'hFFFF, 16'h0000, 16'h8000}, 1'b1)};
    // Zero weight freezes the average; a window above the depth acts as the depth.
    plan = {plan, reg_row(CFG_ALPHA, 17'd0)};
    plan = {plan, reg_row(CFG_WINDOW, 17'h1FFFF)};
    plan = {plan, frame_row('{7{16'h0000}}, 1'b0)};
    plan = {plan, frame_row('{7{16'hFFFF}}, 1'b0)};
    // Writes to unused register indexes change nothing.
    plan = {plan, reg_row(CFG_SPARE_LO, 17'd3)};
    plan = {plan, reg_row(CFG_SPARE_HI, 17'h1FFFF)};
    plan = {plan, frame_row('{16'h4000, 16'hC000, 16'h0000, 16'hFFFF,
                              16'h0001, 16'h0002, 16'h0003}, 1'b0)};
    // Even window: the upper median.
    plan = {plan, reg_row(CFG_ALPHA, 17'd65535)};
    plan = {plan, reg_row(CFG_WINDOW, 17'd2)};
    plan = {plan, frame_row('{16'h0000, 16'h1111, 16'h2222, 16'h3333,
                              16'h4444, 16'h5555, 16'h6666}, 1'b0)};
    plan = {plan, frame_row('{16'hFFFF, 16'hEEEE, 16'hDDDD, 16'hCCCC,
                              16'hBBBB, 16'hAAAA, 16'h9999}, 1'b0)};
    plan = {plan, frame_row('{7{16'h8000}}, 1'b0)};
    plan = {plan, reg_row(CFG_ALPHA, 17'd32768)};
    plan = {plan, reg_row(CFG_WINDOW, 17'd3)};
    plan = {plan, frame_row('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                              16'h0000, 16'hFFFF, 16'h0000}, 1'b0)};
    plan = {plan, frame_row('{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                              16'h0FED, 16'hCBA9, 16'h8765}, 1'b0)};
    plan = {plan, frame_row('{7{16'h0001}}, 1'b0)};
    // Growing the window takes in older frames still held.
    plan = {plan, reg_row(CFG_WINDOW, 17'd64)};
    plan = {plan, frame_row('{7{16'hFFFE}}, 1'b0)};
    plan = {plan, frame_row('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                              16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0)};

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        write_reg(plan[i].reg_index, plan[i].wr_data);
      end else begin
        send_frame(plan[i].frame, plan[i].echoes_input);
      end
    end

    // Random phases, each behind its own register settings.
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      last_stretch = (RANDOM_FRAMES - sent) <= QUIET_TAIL;
      idle_on = last_stretch ? 1'b0 : ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0:       data = '0;
          1:       data = 17'd1;
          2:       data = 17'd65535;
          3:       data = ALPHA_ONE;
          4:       data = CFG_DATA_W'($urandom_range(int'(ALPHA_ONE) + 1, 17'h1FFFF));
          default: data = CFG_DATA_W'($urandom_range(0, int'(ALPHA_ONE)));
        endcase
        write_reg(CFG_ALPHA, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 8))
          0:       data = '0;
          1:       data = 17'd1;
          2:       data = 17'd2;
          3:       data = CFG_DATA_W'(DEPTH);
          4:       data = {10'($urandom), 7'($urandom_range(DEPTH + 1, 127))};
          8:       data = CFG_DATA_W'($urandom_range(1, DEPTH));
          default: data = CFG_DATA_W'($urandom_range(1, 16));
        endcase
        write_reg(CFG_WINDOW, data);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_SPARE_LO), int'(CFG_SPARE_HI))),
                  17'($urandom));
      end

      phase_len = last_stretch ? RANDOM_FRAMES - sent : $urandom_range(20, 120);
      if (phase_len > RANDOM_FRAMES - sent) phase_len = RANDOM_FRAMES - sent;
      frame_mode = $urandom_range(0, 3);
      repeat (phase_len) begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
          case ((frame_mode == 3) ? $urandom_range(0, 2) : frame_mode)
            // A handful of values, so ranks see many ties.
            1: begin
              case ($urandom_range(0, 3))
                0:       lane = 16'h0000;
                1:       lane = 16'h0001;
                2:       lane = 16'h8000;
                default: lane = 16'hFFFF;
              endcase
            end
            2:       lane = 16'h8000 + 16'($urandom_range(0, 15));
            default: lane = 16'($urandom_range(0, 65535));
          endcase
          bits[SAMPLE_BITS*c +: SAMPLE_BITS] = lane;
        end
        send_frame(in_payload_t'(bits), 1'b0);
        sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
          pause_sender($urandom_range(1, 7));
        end else if (!last_stretch && $urandom_range(0, 59) == 0) begin
          wait_drained();
        end
      end
    end

    // Let the last results come back, then watch for strays.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("ema_then_sliding_median verification clean");
    end else begin
      $display("ema_then_sliding_median verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("ema_then_sliding_median verification failed");
    $finish;
  end

endmodule
